// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks are cut out of synthesis; each macro takes a label, clock, active-low
// reset and the property parts.
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/tmt_pkg.sv -----
`timescale 1ns / 1ps

package tmt_pkg;

  localparam int DEF_ENTRIES = 16;

  localparam int OP_W     = 2;
  localparam int TAG_W    = 32;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd3;

  localparam logic [TAG_W-1:0] FREE_TAG = '0;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd4;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               locked;
    logic [OWNER_W-1:0] owner;
  } entry_t;

endpackage

// ----- sv/tagged_mutex_table.sv -----
// Answers: a request with the reserved tag is answered in the cycle after start; any other
//   scans entries from index 0, reading each into rd_data_r, until a match or the last entry.
// Requests: one at a time, taken only while idle; the scan reads the entry memory
//   one entry per cycle.
// Reset: table empties at once (per-entry valid bits clear); no clearing pass.
// The receiver cannot stall: out_strobe marks each word for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tagged_mutex_table
  import tmt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            in_operation,
  input  logic signed [TAG_W-1:0]    in_tag,
  input  logic [OWNER_W-1:0]         in_requester_id,
  output logic                       out_strobe,
  output logic [STATUS_W-1:0]        out_status,
  output logic [SLOT_W-1:0]          out_slot
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t               state_r;
  logic [OP_W-1:0]      op_r;
  logic [TAG_W-1:0]     tag_r;
  logic [OWNER_W-1:0]   who_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 iss_r;
  logic [IDX_W-1:0]     chk_idx_r;
  logic                 chk_vld_r;
  logic [ENTRIES-1:0]   vld_r;
  logic                 rd_ok_r;
  entry_t               rd_data_r;
  logic                 out_strobe_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;

  entry_t               mem [ENTRIES];

  entry_t               cur;
  logic [TAG_W-1:0]     key;
  logic                 hit;
  logic                 done_hit;
  logic                 done_miss;
  logic                 wr_en;
  entry_t               wr_entry;
  logic [STATUS_W-1:0]  hit_status;

  // never-written entries read as free/unlocked
  assign cur      = rd_ok_r ? rd_data_r : '0;
  assign key      = (op_r == OP_CREATE) ? FREE_TAG : tag_r;
  assign hit      = (cur.tag == key);
  assign done_hit  = (state_r == S_SCAN) && chk_vld_r && hit;
  assign done_miss = (state_r == S_SCAN) && chk_vld_r && !hit && (chk_idx_r == LAST);

  always_comb begin
    wr_entry   = cur;
    hit_status = ST_OK;
    case (op_r)
      OP_CREATE: begin
        wr_entry.tag    = tag_r;
        wr_entry.locked = 1'b0;
        wr_entry.owner  = '0;
      end
      OP_ACQUIRE: begin
        if (cur.locked) begin
          hit_status = ST_BUSY;
        end
        wr_entry.locked = 1'b1;
        wr_entry.owner  = who_r;
      end
      OP_RELEASE: begin
        wr_entry.locked = 1'b0;
        wr_entry.owner  = '0;
      end
      default: begin
        // destroy frees the tag only; lock and owner wait for the next create
        wr_entry.tag = FREE_TAG;
      end
    endcase
  end

  assign wr_en = done_hit && (hit_status == ST_OK);

  // entry memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx_r];
    if (wr_en) begin
      mem[chk_idx_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iss_r        <= 1'b0;
      chk_vld_r    <= 1'b0;
      rd_ok_r      <= 1'b0;
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      rd_ok_r      <= vld_r[rd_idx_r];
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r  <= in_operation;
            tag_r <= in_tag;
            who_r <= in_requester_id;
            if (in_tag == FREE_TAG) begin
              out_strobe_r <= 1'b1;
              out_status_r <= ST_RESERVED;
              out_slot_r   <= '0;
            end else begin
              state_r   <= S_SCAN;
              rd_idx_r  <= '0;
              iss_r     <= 1'b1;
              chk_vld_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // read of rd_idx_r lands next cycle, checked against chk_idx_r
          chk_vld_r <= iss_r;
          chk_idx_r <= rd_idx_r;
          if (iss_r) begin
            if (rd_idx_r == LAST) begin
              iss_r <= 1'b0;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          if (done_hit) begin
            state_r      <= S_IDLE;
            iss_r        <= 1'b0;
            chk_vld_r    <= 1'b0;
            out_strobe_r <= 1'b1;
            out_status_r <= hit_status;
            out_slot_r   <= SLOT_W'(chk_idx_r);
            if (wr_en) begin
              vld_r[chk_idx_r] <= 1'b1;
            end
          end else if (done_miss) begin
            state_r      <= S_IDLE;
            iss_r        <= 1'b0;
            chk_vld_r    <= 1'b0;
            out_strobe_r <= 1'b1;
            out_status_r <= (op_r == OP_CREATE) ? ST_FULL : ST_NOT_FOUND;
            out_slot_r   <= '0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  `ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `ASSERT_NEXT(a_reserved_answer, clk, rst_n, start && !busy && (in_tag == FREE_TAG),
               out_strobe && (out_status == ST_RESERVED))
  `ASSERT_NEXT(a_scan_starts, clk, rst_n, start && !busy && (in_tag != FREE_TAG),
               busy && !out_strobe)
  `ASSERT_SAME(a_issue_stops_last, clk, rst_n, (state_r == S_SCAN) && !iss_r, rd_idx_r == LAST)
  `ASSERT_HOLDS(a_one_outcome, clk, rst_n, !(done_hit && done_miss))

endmodule
